>>> sv/cayley_spin_update_macros.svh
// Assertion macros of the spin update RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef CAYLEY_SPIN_UPDATE_MACROS_SVH
`define CAYLEY_SPIN_UPDATE_MACROS_SVH
`ifndef SYNTHESIS
`define CSU_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define CSU_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CSU_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define CSU_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> sv/csu_pkg.sv
// Types, constants and fixed-point helpers of the Cayley spin update.
// Depends on nothing; used by csu_cfg_if and every module.
package csu_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;
    localparam int C_W       = 53;
    localparam int DEN_W     = 59;
    localparam int QW        = 41;
    localparam int C_STEPS   = 82;
    localparam int CNT_W     = 7;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TIME_STEP = 3'd0,
        REG_DAMPING_0 = 3'd1,
        REG_DAMPING_1 = 3'd2,
        REG_DAMPING_2 = 3'd3,
        REG_DAMPING_3 = 3'd4
    } t_reg_idx;

    typedef logic signed [31:0] t_w32;
    typedef logic signed [61:0] t_val;
    typedef t_w32 [2:0]         t_v32;
    typedef t_val [2:0]         t_vec;
    typedef logic [DEN_W-1:0]   t_den;
    typedef logic [QW-1:0]      t_inv;

    typedef struct packed {
        logic [C_W-1:0] c1;
        logic [C_W-1:0] c2;
    } t_coef;

    typedef struct packed {
        logic        neg;
        logic [63:0] p11;
        logic [63:0] p10;
        logic [63:0] p01;
        logic [63:0] p00;
    } t_pp;

    typedef struct packed {
        logic func;
        t_v32 s;
        t_v32 b;
        t_vec num;
    } t_side;

    localparam logic signed [63:0] LIM      = 64'sd1 <<< 60;
    localparam t_den               DEN_ONE  = t_den'(1) << 40;
    localparam t_den               DIV_SEED = t_den'(1) << 39;
    localparam int                 NXT [3]  = '{1, 2, 0};
    localparam int                 PRV [3]  = '{2, 0, 1};

    function automatic t_pp pp_mul(input t_val a, input t_val b);
        t_pp         p;
        logic [61:0] ma;
        logic [61:0] mb;
        ma = a[61] ? 62'(-a) : 62'(a);
        mb = b[61] ? 62'(-b) : 62'(b);
        p.neg = a[61] ^ b[61];
        p.p00 = 64'(ma[31:0]) * 64'(mb[31:0]);
        p.p01 = 64'(ma[31:0]) * 64'(mb[61:32]);
        p.p10 = 64'(ma[61:32]) * 64'(mb[31:0]);
        p.p11 = 64'(ma[61:32]) * 64'(mb[61:32]);
        return p;
    endfunction

    // Product shifted right with the magnitude truncated, saturated at 2^60.
    function automatic t_val pp_fin(input t_pp p, input int unsigned sh);
        logic [127:0] full;
        logic [127:0] r;
        logic [61:0]  m;
        full = {p.p11, 64'd0} + {32'd0, p.p01, 32'd0} + {32'd0, p.p10, 32'd0}
             + {64'd0, p.p00};
        r = full >> sh;
        m = (r > 128'(LIM)) ? 62'(LIM) : r[61:0];
        return p.neg ? -$signed(m) : $signed(m);
    endfunction

    function automatic t_val clamp(input logic signed [63:0] v);
        if (v > LIM) begin
            return t_val'(LIM);
        end else if (v < -LIM) begin
            return t_val'(-LIM);
        end
        return v[61:0];
    endfunction

endpackage

>>> sv/csu_if.sv
// Handshake channels of the spin update: input items, results and register writes.
// Depends on csu_pkg for the register index width.
interface csu_in_if;
    logic               valid;
    logic               ready;
    logic               func;
    logic [1:0]         material;
    logic signed [31:0] spin_x;
    logic signed [31:0] spin_y;
    logic signed [31:0] spin_z;
    logic signed [31:0] field_x;
    logic signed [31:0] field_y;
    logic signed [31:0] field_z;
    logic signed [31:0] base_x;
    logic signed [31:0] base_y;
    logic signed [31:0] base_z;
    modport source (output valid, func, material, spin_x, spin_y, spin_z, field_x,
                    field_y, field_z, base_x, base_y, base_z, input ready);
    modport sink (input valid, func, material, spin_x, spin_y, spin_z, field_x,
                  field_y, field_z, base_x, base_y, base_z, output ready);
endinterface

interface csu_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] new_spin_x;
    logic signed [31:0] new_spin_y;
    logic signed [31:0] new_spin_z;
    modport source (output valid, new_spin_x, new_spin_y, new_spin_z, input ready);
    modport sink (input valid, new_spin_x, new_spin_y, new_spin_z, output ready);
endinterface

interface csu_cfg_if import csu_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> sv/csu_coef.sv
// Register file and per-material coefficient table c1 = dt/(1+alpha^2), c2 = c1*alpha.
// Depends on csu_pkg, csu_cfg_if; a bit-serial divider reruns on reset, defined writes.
module csu_coef import csu_pkg::*; #(
    parameter int NUM_MATERIALS = 4,
    parameter int IDX_W         = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    csu_cfg_if.sink          i_cfg,
    input  logic [IDX_W-1:0] i_mat,
    output t_coef            o_coef,
    output logic             o_busy
);

    typedef enum logic [2:0] {ST_IDLE, ST_LOAD, ST_DIV, ST_MUL, ST_STORE} t_state;

    t_state           r_state;
    logic [31:0]      r_time;
    logic [15:0]      r_damp [NUM_MATERIALS];
    t_coef            r_tab  [NUM_MATERIALS];
    logic [IDX_W-1:0] r_m;
    logic [32:0]      r_den;
    logic [32:0]      r_rem;
    logic [31:0]      r_num;
    logic [C_W-1:0]   r_q;
    logic [CNT_W-1:0] r_cnt;
    logic [47:0]      r_plo;
    logic [36:0]      r_phi;
    logic [33:0]      n_sh;
    logic             n_ge;
    logic [68:0]      n_c2;
    logic             w_wr;

    assign i_cfg.ready = 1'b1;
    assign w_wr   = i_cfg.valid && i_cfg.ready;
    assign o_busy = (r_state != ST_IDLE);
    assign o_coef = r_tab[i_mat];

    always_comb begin
        n_sh = {r_rem, r_num[31]};
        n_ge = (n_sh >= {1'b0, r_den});
        n_c2 = {r_phi, 32'd0} + 69'(r_plo);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_m     <= '0;
            r_time  <= 32'd109951163;
            for (int k = 0; k < NUM_MATERIALS; k++) begin
                r_damp[k] <= 16'd3277;
            end
        end else begin
            case (r_state)
                ST_LOAD: begin
                    r_den   <= 33'(r_damp[r_m]) * 33'(r_damp[r_m]) + (33'd1 << 30);
                    r_num   <= r_time;
                    r_rem   <= '0;
                    r_q     <= '0;
                    r_cnt   <= '0;
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    r_rem <= n_ge ? 33'(n_sh - {1'b0, r_den}) : n_sh[32:0];
                    r_q   <= {r_q[C_W-2:0], n_ge};
                    r_num <= {r_num[30:0], 1'b0};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(C_STEPS - 1)) begin
                        r_state <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    r_plo   <= 48'(r_q[31:0]) * 48'(r_damp[r_m]);
                    r_phi   <= 37'(r_q[C_W-1:32]) * 37'(r_damp[r_m]);
                    r_state <= ST_STORE;
                end
                ST_STORE: begin
                    r_tab[r_m].c1 <= r_q;
                    r_tab[r_m].c2 <= n_c2[15 +: C_W];
                    if (r_m == IDX_W'(NUM_MATERIALS - 1)) begin
                        r_state <= ST_IDLE;
                    end else begin
                        r_m     <= r_m + 1'b1;
                        r_state <= ST_LOAD;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
            if (w_wr) begin
                if (i_cfg.index == REG_TIME_STEP) begin
                    r_time <= i_cfg.data;
                end
                for (int k = 0; k < NUM_MATERIALS; k++) begin
                    if (i_cfg.index == CFG_IDX_W'(REG_DAMPING_0) + CFG_IDX_W'(k)) begin
                        r_damp[k] <= i_cfg.data[15:0];
                    end
                end
                if (i_cfg.index <= REG_DAMPING_3) begin
                    r_m     <= '0;
                    r_state <= ST_LOAD;
                end
            end
        end
    end

endmodule

>>> sv/csu_div.sv
// Pipelined restoring divider giving floor(2^80 / den), one quotient bit per stage.
// Depends on csu_pkg; carries the item's side data alongside the remainder.
module csu_div import csu_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_vld,
    input  t_den  i_den,
    input  t_side i_side,
    output logic  o_vld,
    output t_inv  o_q,
    output t_side o_side
);

    logic [QW-1:0] r_vld;
    t_den          r_rem  [QW];
    t_den          r_den  [QW];
    t_inv          r_q    [QW];
    t_side         r_side [QW];

    for (genvar k = 0; k < QW; k++) begin : g_st
        logic           w_vld;
        t_den           w_rem;
        t_den           w_den;
        t_inv           w_q;
        t_side          w_side;
        logic [DEN_W:0] w_dbl;
        logic           w_ge;

        if (k == 0) begin : g_first
            assign w_vld  = i_vld;
            assign w_rem  = DIV_SEED;
            assign w_den  = i_den;
            assign w_q    = '0;
            assign w_side = i_side;
        end else begin : g_next
            assign w_vld  = r_vld[k-1];
            assign w_rem  = r_rem[k-1];
            assign w_den  = r_den[k-1];
            assign w_q    = r_q[k-1];
            assign w_side = r_side[k-1];
        end

        assign w_dbl = {w_rem, 1'b0};
        assign w_ge  = (w_dbl >= {1'b0, w_den});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= w_ge ? DEN_W'(w_dbl - {1'b0, w_den}) : w_dbl[DEN_W-1:0];
                r_den[k]  <= w_den;
                r_q[k]    <= {w_q[QW-2:0], w_ge};
                r_side[k] <= w_side;
            end
        end
    end

    assign o_vld  = r_vld[QW-1];
    assign o_q    = r_q[QW-1];
    assign o_side = r_side[QW-1];

endmodule

>>> sv/cayley_spin_update.sv
// Top level of the semi-implicit Cayley spin update kernel.
// Depends on csu_pkg, the csu_if interfaces, csu_coef and csu_div.
//
//  channel   modport  direction  payload
//  i_item    sink     in         func, material, spin, field, base
//  o_item    source   out        new_spin
//  i_cfg     sink     in         register index, data
//
// One item enters per cycle while the output is not stalled and the table is not being rebuilt.
// Each item passes the 41 stages of the reciprocal divider plus 12 datapath stages.
// After reset, and after each write to a defined register, the coefficient table is
// rebuilt one material at a time; no item is taken meanwhile.
// A stall at the output freezes the whole pipeline, so nothing is lost or repeated.
`include "cayley_spin_update_macros.svh"
module cayley_spin_update import csu_pkg::*; #(
    parameter int NUM_MATERIALS = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    csu_in_if.sink    i_item,
    csu_out_if.source o_item,
    csu_cfg_if.sink   i_cfg
);

    localparam int IDX_W = (NUM_MATERIALS > 1) ? $clog2(NUM_MATERIALS) : 1;

    logic             w_en;
    logic             w_busy;
    logic             w_acc;
    logic [IDX_W-1:0] w_mat;
    t_coef            w_coef;
    logic             w_dv_vld;
    t_inv             w_dv_q;
    t_side            w_dv_side;
    t_side            w_side;
    logic [12:0]      w_vld;

    logic r_a_vld, r_b_vld, r_c_vld, r_d_vld, r_e_vld, r_f_vld;
    logic r_g_vld, r_h_vld, r_i_vld, r_j_vld, r_k_vld, r_l_vld;
    logic r_a_func, r_b_func, r_c_func, r_d_func, r_e_func, r_f_func;
    logic r_g_func, r_h_func, r_i_func, r_j_func, r_k_func;
    t_v32 r_a_s, r_b_s, r_c_s, r_d_s, r_e_s, r_f_s, r_g_s, r_h_s, r_i_s, r_j_s, r_k_s;
    t_v32 r_a_b, r_b_b, r_c_b, r_d_b, r_e_b, r_f_b, r_g_b, r_h_b, r_i_b, r_j_b;
    t_v32 r_a_h;
    logic [C_W-1:0] r_a_c1, r_a_c2, r_b_c2, r_c_c2;
    t_pp [5:0] r_b_psh, r_f_pab, r_h_paab;
    t_pp [2:0] r_b_pch, r_d_pav, r_f_psq, r_j_pni;
    t_vec r_c_sxh, r_c_ch, r_d_ch, r_e_av, r_f_av, r_g_av, r_g_axb, r_h_axb;
    t_vec r_i_axb, r_i_aab, r_k_rot;
    t_val r_g_asq;
    t_den r_h_den, r_i_den;
    t_v32 r_l_out;

    csu_coef #(
        .NUM_MATERIALS (NUM_MATERIALS),
        .IDX_W         (IDX_W)
    ) u_coef (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .i_mat   (w_mat),
        .o_coef  (w_coef),
        .o_busy  (w_busy)
    );

    assign w_en         = !r_l_vld || o_item.ready;
    assign i_item.ready = w_en && !w_busy;
    assign w_acc        = i_item.valid && i_item.ready;
    assign w_mat        = ({1'b0, i_item.material} >= 3'(NUM_MATERIALS))
                        ? IDX_W'(NUM_MATERIALS - 1) : IDX_W'(i_item.material);

    always_comb begin
        w_side.func = r_i_func;
        w_side.s    = r_i_s;
        w_side.b    = r_i_b;
        for (int i = 0; i < 3; i++) begin
            w_side.num[i] = clamp((64'(r_i_axb[i]) <<< 1) + 64'(r_i_aab[i]));
        end
    end

    csu_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_i_vld),
        .i_den   (r_i_den),
        .i_side  (w_side),
        .o_vld   (w_dv_vld),
        .o_q     (w_dv_q),
        .o_side  (w_dv_side)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0; r_b_vld <= 1'b0; r_c_vld <= 1'b0; r_d_vld <= 1'b0;
            r_e_vld <= 1'b0; r_f_vld <= 1'b0; r_g_vld <= 1'b0; r_h_vld <= 1'b0;
            r_i_vld <= 1'b0; r_j_vld <= 1'b0; r_k_vld <= 1'b0; r_l_vld <= 1'b0;
        end else if (w_en) begin
            r_a_vld <= w_acc;   r_b_vld <= r_a_vld; r_c_vld <= r_b_vld;
            r_d_vld <= r_c_vld; r_e_vld <= r_d_vld; r_f_vld <= r_e_vld;
            r_g_vld <= r_f_vld; r_h_vld <= r_g_vld; r_i_vld <= r_h_vld;
            r_j_vld <= w_dv_vld; r_k_vld <= r_j_vld; r_l_vld <= r_k_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [63:0] v_w;
        logic signed [63:0] v_sum;
        if (w_en) begin
            r_a_func <= i_item.func;
            r_a_s    <= {i_item.spin_z, i_item.spin_y, i_item.spin_x};
            r_a_h    <= {i_item.field_z, i_item.field_y, i_item.field_x};
            r_a_b    <= i_item.func ? {i_item.base_z, i_item.base_y, i_item.base_x}
                                    : {i_item.spin_z, i_item.spin_y, i_item.spin_x};
            r_a_c1   <= w_coef.c1;
            r_a_c2   <= w_coef.c2;

            r_b_func <= r_a_func; r_b_s <= r_a_s; r_b_b <= r_a_b; r_b_c2 <= r_a_c2;
            for (int i = 0; i < 3; i++) begin
                r_b_psh[2*i]   <= pp_mul(t_val'($signed(r_a_s[NXT[i]])),
                                         t_val'($signed(r_a_h[PRV[i]])));
                r_b_psh[2*i+1] <= pp_mul(t_val'($signed(r_a_s[PRV[i]])),
                                         t_val'($signed(r_a_h[NXT[i]])));
                r_b_pch[i]     <= pp_mul(t_val'(r_a_c1), t_val'($signed(r_a_h[i])));
            end

            r_c_func <= r_b_func; r_c_s <= r_b_s; r_c_b <= r_b_b; r_c_c2 <= r_b_c2;
            for (int i = 0; i < 3; i++) begin
                r_c_sxh[i] <= clamp(64'(pp_fin(r_b_psh[2*i], 10))
                                  - 64'(pp_fin(r_b_psh[2*i+1], 10)));
                r_c_ch[i]  <= pp_fin(r_b_pch[i], 40);
            end

            r_d_func <= r_c_func; r_d_s <= r_c_s; r_d_b <= r_c_b; r_d_ch <= r_c_ch;
            for (int i = 0; i < 3; i++) begin
                r_d_pav[i] <= pp_mul(t_val'(r_c_c2), r_c_sxh[i]);
            end

            r_e_func <= r_d_func; r_e_s <= r_d_s; r_e_b <= r_d_b;
            for (int i = 0; i < 3; i++) begin
                r_e_av[i] <= clamp(64'(r_d_ch[i]) + 64'(pp_fin(r_d_pav[i], 60)));
            end

            r_f_func <= r_e_func; r_f_s <= r_e_s; r_f_b <= r_e_b; r_f_av <= r_e_av;
            for (int i = 0; i < 3; i++) begin
                r_f_psq[i]     <= pp_mul(r_e_av[i], r_e_av[i]);
                r_f_pab[2*i]   <= pp_mul(r_e_av[NXT[i]],
                                         t_val'($signed(r_e_b[PRV[i]])) <<< 10);
                r_f_pab[2*i+1] <= pp_mul(r_e_av[PRV[i]],
                                         t_val'($signed(r_e_b[NXT[i]])) <<< 10);
            end

            r_g_func <= r_f_func; r_g_s <= r_f_s; r_g_b <= r_f_b; r_g_av <= r_f_av;
            v_sum = 64'(pp_fin(r_f_psq[0], 40)) + 64'(pp_fin(r_f_psq[1], 40))
                  + 64'(pp_fin(r_f_psq[2], 40));
            r_g_asq <= clamp(v_sum);
            for (int i = 0; i < 3; i++) begin
                r_g_axb[i] <= clamp(64'(pp_fin(r_f_pab[2*i], 40))
                                  - 64'(pp_fin(r_f_pab[2*i+1], 40)));
            end

            r_h_func <= r_g_func; r_h_s <= r_g_s; r_h_b <= r_g_b; r_h_axb <= r_g_axb;
            r_h_den  <= DEN_ONE + t_den'(r_g_asq[61:2]);
            for (int i = 0; i < 3; i++) begin
                r_h_paab[2*i]   <= pp_mul(r_g_av[NXT[i]], r_g_axb[PRV[i]]);
                r_h_paab[2*i+1] <= pp_mul(r_g_av[PRV[i]], r_g_axb[NXT[i]]);
            end

            r_i_func <= r_h_func; r_i_s <= r_h_s; r_i_b <= r_h_b; r_i_axb <= r_h_axb;
            r_i_den  <= r_h_den;
            for (int i = 0; i < 3; i++) begin
                r_i_aab[i] <= clamp(64'(pp_fin(r_h_paab[2*i], 40))
                                  - 64'(pp_fin(r_h_paab[2*i+1], 40)));
            end

            r_j_func <= w_dv_side.func; r_j_s <= w_dv_side.s; r_j_b <= w_dv_side.b;
            for (int i = 0; i < 3; i++) begin
                r_j_pni[i] <= pp_mul(w_dv_side.num[i], t_val'(w_dv_q));
            end

            r_k_func <= r_j_func; r_k_s <= r_j_s;
            for (int i = 0; i < 3; i++) begin
                r_k_rot[i] <= clamp((64'($signed(r_j_b[i])) <<< 10)
                                  + 64'(pp_fin(r_j_pni[i], 41)));
            end

            for (int i = 0; i < 3; i++) begin
                if (r_k_func) begin
                    v_w = (64'(r_k_rot[i]) + 64'sd512) >>> 10;
                end else begin
                    v_w = (64'(r_k_rot[i]) + (64'($signed(r_k_s[i])) <<< 10)
                           + 64'sd1024) >>> 11;
                end
                if (v_w > 64'sd2147483647) begin
                    r_l_out[i] <= 32'sh7fffffff;
                end else if (v_w < -64'sd2147483648) begin
                    r_l_out[i] <= 32'sh80000000;
                end else begin
                    r_l_out[i] <= v_w[31:0];
                end
            end
        end
    end

    assign o_item.valid      = r_l_vld;
    assign o_item.new_spin_x = r_l_out[0];
    assign o_item.new_spin_y = r_l_out[1];
    assign o_item.new_spin_z = r_l_out[2];

    assign w_vld = {r_a_vld, r_b_vld, r_c_vld, r_d_vld, r_e_vld, r_f_vld, r_g_vld,
                    r_h_vld, r_i_vld, w_dv_vld, r_j_vld, r_k_vld, r_l_vld};

    `CSU_ASSERT_IMP(a_ready_idle, i_clk, i_rst_n, i_item.ready, !w_busy, "item taken while coefficients rebuild")
    `CSU_ASSERT_NXT(a_accept_enters, i_clk, i_rst_n, w_acc, r_a_vld, "accepted beat missing from first stage")
    `CSU_ASSERT_NXT(a_stall_hold, i_clk, i_rst_n, o_item.valid && !o_item.ready, $stable(w_vld), "pipeline moved during an output stall")
    `CSU_ASSERT_NXT(a_drain, i_clk, i_rst_n, o_item.valid && o_item.ready && !r_k_vld, !o_item.valid, "result repeated after its beat")

endmodule

>>> test/cayley_spin_update_tb.sv
// Self-checking testbench of the Cayley spin update kernel, driving random and directed atoms.
// Depends on csu_pkg, the csu_if interfaces and the cayley_spin_update RTL.
`timescale 1ns / 1ps
module cayley_spin_update_tb import csu_pkg::*; ();

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd5;
    localparam longint               SAT_LIM    = 64'sd1 <<< 60;

    typedef longint t_vec3 [3];

    typedef struct {
        logic               func;
        logic [1:0]         material;
        logic signed [31:0] s [3];
        logic signed [31:0] h [3];
        logic signed [31:0] b [3];
    } t_atom;

    typedef struct {
        logic signed [31:0] v [3];
    } t_spin;

    class spin_scoreboard;
        logic [31:0] time_step;
        logic [15:0] damping [4];
        t_spin       pending [$];
        int          n_errors;
        int          n_atoms;
        int          n_spins;
        int          n_corrector;

        function new();
            time_step = 32'd109951163;
            foreach (damping[i]) damping[i] = 16'd3277;
            n_errors = 0;
            n_atoms = 0;
            n_spins = 0;
            n_corrector = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
            case (idx)
                REG_TIME_STEP: time_step = data;
                REG_DAMPING_0: damping[0] = data[15:0];
                REG_DAMPING_1: damping[1] = data[15:0];
                REG_DAMPING_2: damping[2] = data[15:0];
                REG_DAMPING_3: damping[3] = data[15:0];
                default: ;
            endcase
        endfunction

        function longint clip(longint v);
            if (v > SAT_LIM) return SAT_LIM;
            if (v < -SAT_LIM) return -SAT_LIM;
            return v;
        endfunction

        function longint mul_shift(longint a, longint b, int sh);
            logic [63:0]  ma;
            logic [63:0]  mb;
            logic [127:0] r;
            longint       m;
            ma = (a < 0) ? -a : a;
            mb = (b < 0) ? -b : b;
            r = (128'(ma) * 128'(mb)) >> sh;
            if (r > 128'(SAT_LIM)) r = 128'(SAT_LIM);
            m = longint'(r[63:0]);
            return ((a < 0) != (b < 0)) ? -m : m;
        endfunction

        function t_vec3 cross_shift(t_vec3 a, t_vec3 b, int sh);
            t_vec3 r;
            r[0] = clip(mul_shift(a[1], b[2], sh) - mul_shift(a[2], b[1], sh));
            r[1] = clip(mul_shift(a[2], b[0], sh) - mul_shift(a[0], b[2], sh));
            r[2] = clip(mul_shift(a[0], b[1], sh) - mul_shift(a[1], b[0], sh));
            return r;
        endfunction

        function logic signed [31:0] round_sat(longint v, int sh);
            longint r;
            r = (v + (64'sd1 <<< (sh - 1))) >>> sh;
            if (r > 64'sd2147483647) r = 64'sd2147483647;
            if (r < -64'sd2147483648) r = -64'sd2147483648;
            return r[31:0];
        endfunction

        function void note(t_atom x);
            t_vec3        s, h, bv, sxh, av, axb, aaxb;
            logic [63:0]  alpha, den;
            logic [127:0] wide;
            longint       c1, c2, asq, inv, num, rot;
            t_spin        e;
            alpha = 64'(damping[x.material]);
            for (int i = 0; i < 3; i++) begin
                s[i] = x.s[i];
                h[i] = x.h[i];
                bv[i] = x.func ? longint'(x.b[i]) * 1024 : longint'(x.s[i]) * 1024;
            end
            den = (64'd1 << 30) + alpha * alpha;
            wide = (128'(time_step) << 50) / 128'(den);
            c1 = longint'(wide[63:0]);
            c2 = mul_shift(c1, longint'(alpha), 15);
            sxh = cross_shift(s, h, 10);
            asq = 0;
            for (int i = 0; i < 3; i++) begin
                av[i] = clip(mul_shift(c1, h[i], 40) + mul_shift(c2, sxh[i], 60));
                asq += mul_shift(av[i], av[i], 40);
            end
            asq = clip(asq);
            wide = (128'd1 << 80) / (128'(64'd1 << 40) + 128'(asq >>> 2));
            inv = longint'(wide[63:0]);
            axb = cross_shift(av, bv, 40);
            aaxb = cross_shift(av, axb, 40);
            for (int i = 0; i < 3; i++) begin
                num = clip(2 * axb[i] + aaxb[i]);
                rot = clip(bv[i] + mul_shift(num, inv, 41));
                e.v[i] = x.func ? round_sat(rot, 10) : round_sat(rot + s[i] * 1024, 11);
            end
            pending.push_back(e);
            n_atoms++;
            if (x.func) n_corrector++;
        endfunction

        task report(string what);
            $display("mismatch: %s", what);
            n_errors++;
        endtask

        task check(t_spin got);
            t_spin e;
            n_spins++;
            if (pending.size() == 0) begin
                report($sformatf("spin %0d has no atom waiting", n_spins));
            end else begin
                e = pending.pop_front();
                for (int i = 0; i < 3; i++) begin
                    if (got.v[i] !== e.v[i]) begin
                        report($sformatf("spin %0d component %0d: got %h, expected %h",
                                         n_spins, i, got.v[i], e.v[i]));
                    end
                end
            end
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;
    int   idle_pct;
    int   stall_pct;
    int   hold_len;

    csu_in_if  item_if ();
    csu_out_if spin_if ();
    csu_cfg_if cfg_if ();

    spin_scoreboard sb = new();

    cayley_spin_update u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_if.sink),
        .o_item  (spin_if.source),
        .i_cfg   (cfg_if.sink)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("timeout");
        $display("CHECK FAILED");
        $finish;
    end

    // Receiver: random back-pressure, with one long hold-off.
    initial begin
        spin_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_len > 0) begin
                spin_if.ready <= 1'b0;
                hold_len = hold_len - 1;
            end else begin
                spin_if.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        t_atom a;
        t_spin r;
        if (i_rst_n && item_if.valid && item_if.ready) begin
            a.func = item_if.func;
            a.material = item_if.material;
            a.s = '{item_if.spin_x, item_if.spin_y, item_if.spin_z};
            a.h = '{item_if.field_x, item_if.field_y, item_if.field_z};
            a.b = '{item_if.base_x, item_if.base_y, item_if.base_z};
            sb.note(a);
        end
        if (i_rst_n && spin_if.valid && spin_if.ready) begin
            r.v = '{spin_if.new_spin_x, spin_if.new_spin_y, spin_if.new_spin_z};
            sb.check(r);
        end
    end

    task automatic send_atom(t_atom a);
        logic rdy;
        while ($urandom_range(99) < idle_pct) begin
            item_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        item_if.valid <= 1'b1;
        item_if.func <= a.func;
        item_if.material <= a.material;
        item_if.spin_x <= a.s[0];
        item_if.spin_y <= a.s[1];
        item_if.spin_z <= a.s[2];
        item_if.field_x <= a.h[0];
        item_if.field_y <= a.h[1];
        item_if.field_z <= a.h[2];
        item_if.base_x <= a.b[0];
        item_if.base_y <= a.b[1];
        item_if.base_z <= a.b[2];
        do begin
            @(negedge i_clk);
            rdy = item_if.ready;
            @(posedge i_clk);
        end while (!rdy);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        logic rdy;
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data <= data;
        do begin
            @(negedge i_clk);
            rdy = cfg_if.ready;
            @(posedge i_clk);
        end while (!rdy);
        cfg_if.valid <= 1'b0;
        sb.write_reg(idx, data);
        @(posedge i_clk);
    endtask

    task automatic drain();
        int n;
        n = 0;
        item_if.valid <= 1'b0;
        while (sb.pending.size() != 0 && n < 200000) begin
            @(posedge i_clk);
            n++;
        end
        repeat (80) @(posedge i_clk);
    endtask

    function automatic logic signed [31:0] rand_comp(int max_shift);
        return $signed($urandom()) >>> $urandom_range(max_shift);
    endfunction

    function automatic t_atom rand_atom();
        t_atom a;
        a.func = $urandom_range(1);
        a.material = $urandom_range(3);
        for (int i = 0; i < 3; i++) begin
            if ($urandom_range(9) < 8) begin
                a.s[i] = $signed($urandom_range(32'h8000_0000)) - 32'sh4000_0000;
                a.b[i] = $signed($urandom_range(32'h8000_0000)) - 32'sh4000_0000;
            end else begin
                a.s[i] = $urandom();
                a.b[i] = $urandom();
            end
            a.h[i] = rand_comp(14);
        end
        return a;
    endfunction

    function automatic t_atom fill_atom(logic f, logic [1:0] m, logic signed [31:0] sv,
                                        logic signed [31:0] hv, logic signed [31:0] bv);
        t_atom a;
        a.func = f;
        a.material = m;
        a.s = '{sv, -sv, sv >>> 1};
        a.h = '{hv, hv >>> 3, -hv};
        a.b = '{bv, bv >>> 2, -bv};
        return a;
    endfunction

    initial begin
        i_rst_n = 1'b0;
        hold_len = 0;
        idle_pct = 0;
        stall_pct = 0;
        item_if.valid = 1'b0;
        item_if.func = 1'b0;
        item_if.material = '0;
        item_if.spin_x = '0;
        item_if.spin_y = '0;
        item_if.spin_z = '0;
        item_if.field_x = '0;
        item_if.field_y = '0;
        item_if.field_z = '0;
        item_if.base_x = '0;
        item_if.base_y = '0;
        item_if.base_z = '0;
        cfg_if.valid = 1'b0;
        cfg_if.index = '0;
        cfg_if.data = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed atoms under the reset settings.
        send_atom(fill_atom(1'b0, 2'd0, 32'sd0, 32'sd0, 32'sd0));
        send_atom(fill_atom(1'b1, 2'd1, 32'sh4000_0000, 32'sh0010_0000, 32'sh4000_0000));
        send_atom(fill_atom(1'b0, 2'd2, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff));
        send_atom(fill_atom(1'b1, 2'd3, -32'sh8000_0000, -32'sh8000_0000, -32'sh8000_0000));
        send_atom(fill_atom(1'b0, 2'd3, 32'sh4000_0000, -32'sh8000_0000, 32'sh1234_5678));
        send_atom(fill_atom(1'b1, 2'd2, -32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff));
        send_atom(fill_atom(1'b0, 2'd1, 32'sh2d41_3ccc, 32'sh0640_0000, -32'sh8000_0000));
        send_atom(fill_atom(1'b1, 2'd0, 32'sh2d41_3ccc, -32'sh0640_0000, 32'sh0000_0001));
        send_atom(fill_atom(1'b1, 2'd0, 32'sh0000_0001, 32'sh0000_0001, 32'sh0));
        send_atom(fill_atom(1'b0, 2'd2, -32'sh0000_0001, -32'sh0000_0001, -32'sh1));

        for (int phase = 0; phase < 7; phase++) begin
            drain();
            case (phase % 4)
                0: begin idle_pct = 0; stall_pct = 0; end
                1: begin idle_pct = 51; stall_pct = 0; end
                2: begin idle_pct = 0; stall_pct = 51; end
                default: begin idle_pct = 26; stall_pct = 26; end
            endcase
            if (phase == 1) begin
                write_reg(REG_TIME_STEP, 32'hffff_ffff);
                write_reg(REG_DAMPING_0, 32'h0000_ffff);
                write_reg(REG_DAMPING_1, 32'h0000_ffff);
                write_reg(REG_DAMPING_2, 32'h0000_ffff);
                write_reg(REG_DAMPING_3, 32'h0000_ffff);
            end else if (phase == 2) begin
                write_reg(REG_TIME_STEP, 32'd0);
                write_reg(REG_DAMPING_0, 32'd0);
                write_reg(REG_DAMPING_2, 32'd0);
                write_reg(REG_UNUSED, 32'hdead_beef);
                hold_len = 400;
            end else if (phase > 2) begin
                write_reg(REG_TIME_STEP, $urandom() >> $urandom_range(12));
                write_reg(REG_DAMPING_0, $urandom_range(65535));
                write_reg(REG_DAMPING_1, $urandom_range(65535));
                write_reg(REG_DAMPING_2, $urandom_range(65535));
                write_reg(REG_DAMPING_3, $urandom_range(65535));
            end
            for (int k = 0; k < 120; k++) send_atom(rand_atom());
        end
        drain();

        $display("Covered %0d atoms (%0d corrector) over seven register settings,",
                 sb.n_atoms, sb.n_corrector);
        $display("with idle, stall and long hold-off phases; %0d spins checked.", sb.n_spins);
        if (sb.n_errors == 0 && sb.pending.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

>>> filelist.f
+incdir+sv
sv/csu_pkg.sv
sv/csu_if.sv
sv/csu_coef.sv
sv/csu_div.sv
sv/cayley_spin_update.sv
test/cayley_spin_update_tb.sv
